// ===== design/fsc_pkg.sv =====
// Shared types and constants of the falling-sand cell stepper.
// Used by the channel interfaces and by falling_sand_cell_step_unit.
// Depends on nothing.
package fsc_pkg;

   localparam int DEF_MAX_COLS  = 256;
   localparam int DEF_MAX_ROWS  = 256;
   localparam int DEF_KIND_BITS = 8;

   localparam int CMD_W     = 2;
   localparam int COORD_W   = 8;
   localparam int KIND_W    = 8;
   localparam int OUTCOME_W = 2;
   localparam int DIM_W     = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0]  RST_GRID_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]  RST_GRID_HEIGHT = 9'd256;
   localparam logic [KIND_W-1:0] RST_SAND_KIND   = 8'd1;
   localparam logic [KIND_W-1:0] RST_EMPTY_KIND  = 8'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2
   } cmd_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_STAYED = 2'd0,
      OUT_FELL   = 2'd1,
      OUT_LEFT   = 2'd2,
      OUT_RIGHT  = 2'd3
   } outcome_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_SAND_KIND   = 2'd2,
      CSR_EMPTY_KIND  = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CELL,
      S_BELOW,
      S_DIAG,
      S_CLEAR,
      S_DONE
   } state_type;

endpackage

// ===== design/fsc_chan_if.sv =====
// Request and response channels of the falling-sand cell stepper.
// Valid/ready handshake with payload; widths come from fsc_pkg.
interface fsc_req_if import fsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic [KIND_W-1:0]  kind_in;
   logic               go_right;

   modport source (output valid, cmd, col, row, kind_in, go_right, input ready);
   modport sink   (input valid, cmd, col, row, kind_in, go_right, output ready);
endinterface

interface fsc_rsp_if import fsc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    cell_kind;
   logic [OUTCOME_W-1:0] outcome;
   logic                 bad_coord;

   modport source (output valid, cell_kind, outcome, bad_coord, input ready);
   modport sink   (input valid, cell_kind, outcome, bad_coord, output ready);
endinterface

// ===== design/falling_sand_cell_step_unit.sv =====
// Top level of the falling-sand cell stepper: grid memory and step sequencer.
// Depends on fsc_pkg and the channel interfaces in fsc_chan_if.sv.
//
// Usage:
//   req_chan carries one request: write a cell, read a cell, or step a cell.
//   rsp_chan returns one response per request: the old kind of the addressed
//   cell, the move outcome and a flag for coordinates outside the grid.
//   csr_* writes grid_width, grid_height, sand_kind and empty_kind; write them
//   only while no request is in flight.
// Timing:
//   The grid sits in a single-port memory with a registered read. A request is
//   taken on accept; then the sequencer walks the memory port one access a
//   cycle: centre read, below read, diagonal read, write of the target,
//   clearing of the source, response load, as far as the request needs them.
//   A bad coordinate goes straight to the response load.
//   A new request is taken once the previous one has loaded its response, so
//   a held response does not block the next request until it too finishes.
// Reset:
//   Synchronous, active high; clears the sequencer and the response flag and
//   restores register defaults. Grid contents are undefined until written.
//   A stalled receiver holds the response register and the sequencer waits.
module falling_sand_cell_step_unit import fsc_pkg::*; #(
   parameter int MAX_COLS  = DEF_MAX_COLS,
   parameter int MAX_ROWS  = DEF_MAX_ROWS,
   parameter int KIND_BITS = DEF_KIND_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   fsc_req_if.sink              req_chan,
   fsc_rsp_if.source            rsp_chan,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int CELLS  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   // configuration
   logic [DIM_W-1:0]  grid_width_ff, grid_height_ff;
   logic [KIND_W-1:0] sand_kind_ff, empty_kind_ff;

   // sequencer and request registers
   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [KIND_BITS-1:0]  kind_in_ff;
   logic                  go_right_ff;
   logic                  bad_ff;
   logic                  has_below_ff, has_right_ff, has_left_ff;
   logic [ADDR_W-1:0]     centre_ff;
   logic [KIND_BITS-1:0]  old_ff;
   outcome_type           outcome_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff;
   outcome_type           rsp_outcome_ff;
   logic                  rsp_bad_ff;

   // grid memory
   logic [KIND_BITS-1:0]  grid_mem [CELLS];
   logic [KIND_BITS-1:0]  rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [KIND_BITS-1:0]  mem_wdata;

   logic                  req_ready;
   logic                  accept;
   logic                  load_rsp;
   logic                  slot_free;
   logic                  col_ok, row_ok, bad_now;
   logic [ADDR_W-1:0]     req_addr, below_addr, diag_addr;
   logic [KIND_BITS-1:0]  sand_k, empty_k;
   logic                  rd_is_empty, rd_is_sand, side_ok;

   assign sand_k  = KIND_BITS'(sand_kind_ff);
   assign empty_k = KIND_BITS'(empty_kind_ff);

   assign accept    = req_chan.valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // coordinate checks against both the programmed grid and the memory size
   assign col_ok  = ({1'b0, req_chan.col} < grid_width_ff)
                    && (32'(req_chan.col) < 32'(MAX_COLS));
   assign row_ok  = ({1'b0, req_chan.row} < grid_height_ff)
                    && (32'(req_chan.row) < 32'(MAX_ROWS));
   assign bad_now = !(col_ok && row_ok);

   assign req_addr   = ADDR_W'(32'(req_chan.row) * 32'(MAX_COLS) + 32'(req_chan.col));
   assign below_addr = centre_ff + ADDR_W'(MAX_COLS);
   assign diag_addr  = go_right_ff ? below_addr + ADDR_W'(1) : below_addr - ADDR_W'(1);

   assign rd_is_empty = (rd_data_ff == empty_k);
   assign rd_is_sand  = (rd_data_ff == sand_k);
   assign side_ok     = go_right_ff ? has_right_ff : has_left_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = bad_now ? S_DONE : S_CELL;
            end
         end
         S_CELL: begin
            if (cmd_ff == CMD_STEP && rd_is_sand && has_below_ff) begin
               state_in = S_BELOW;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BELOW: begin
            if (rd_is_empty) begin
               state_in = S_CLEAR;
            end else if (side_ok) begin
               state_in = S_DIAG;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIAG:  state_in = rd_is_empty ? S_CLEAR : S_DONE;
         S_CLEAR: state_in = S_DONE;
         S_DONE:  state_in = slot_free ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory port and handshake outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = centre_ff;
      mem_wdata = sand_k;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            mem_addr  = req_addr;
         end
         S_CELL: begin
            if (cmd_ff == CMD_WRITE) begin
               mem_we    = 1'b1;
               mem_addr  = centre_ff;
               mem_wdata = kind_in_ff;
            end else begin
               mem_addr = below_addr;
            end
         end
         S_BELOW: begin
            mem_we   = rd_is_empty;
            mem_addr = rd_is_empty ? below_addr : diag_addr;
         end
         S_DIAG: begin
            mem_we   = rd_is_empty;
            mem_addr = diag_addr;
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = centre_ff;
            mem_wdata = empty_k;
         end
         S_DONE:  load_rsp = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= grid_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= RST_GRID_WIDTH;
         grid_height_ff <= RST_GRID_HEIGHT;
         sand_kind_ff   <= RST_SAND_KIND;
         empty_kind_ff  <= RST_EMPTY_KIND;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            CSR_SAND_KIND:   sand_kind_ff   <= csr_wdata[KIND_W-1:0];
            CSR_EMPTY_KIND:  empty_kind_ff  <= csr_wdata[KIND_W-1:0];
            default: ;
         endcase
      end
   end

   // request payload, captured on accept, and the old cell kind, captured in S_CELL
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_chan.cmd;
         kind_in_ff   <= KIND_BITS'(req_chan.kind_in);
         go_right_ff  <= req_chan.go_right;
         bad_ff       <= bad_now;
         centre_ff    <= req_addr;
         has_below_ff <= (9'(req_chan.row) + 9'd1 < grid_height_ff)
                         && (32'(req_chan.row) + 32'd1 < 32'(MAX_ROWS));
         has_right_ff <= (9'(req_chan.col) + 9'd1 < grid_width_ff)
                         && (32'(req_chan.col) + 32'd1 < 32'(MAX_COLS));
         has_left_ff  <= (req_chan.col != '0);
      end
      if (state_ff == S_CELL) begin
         old_ff <= rd_data_ff;
      end
   end

   // outcome: reset on accept, set when the target write happens
   always_ff @(posedge clock) begin
      if (accept) begin
         outcome_ff <= OUT_STAYED;
      end else if (state_ff == S_BELOW && rd_is_empty) begin
         outcome_ff <= OUT_FELL;
      end else if (state_ff == S_DIAG && rd_is_empty) begin
         outcome_ff <= go_right_ff ? OUT_RIGHT : OUT_LEFT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_kind_ff    <= bad_ff ? '0 : KIND_W'(old_ff);
         rsp_outcome_ff <= bad_ff ? OUT_STAYED : outcome_ff;
         rsp_bad_ff     <= bad_ff;
      end
   end

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.cell_kind = rsp_kind_ff;
   assign rsp_chan.outcome   = rsp_outcome_ff;
   assign rsp_chan.bad_coord = rsp_bad_ff;

`ifndef SYNTHESIS
   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != S_IDLE && state_ff != S_DONE))
      else $error("grid write outside an active request");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer did not start on an accepted request");

   a_clear_after_move: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> ($past(state_ff) == S_BELOW || $past(state_ff) == S_DIAG))
      else $error("source cleared without a move");

   a_move_only_on_step: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && outcome_ff != OUT_STAYED && !bad_ff) |-> cmd_ff == CMD_STEP)
      else $error("move reported for a non-step request");

   a_bad_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_outcome_ff == OUT_STAYED && rsp_kind_ff == '0))
      else $error("bad coordinate response carries data");
`endif

endmodule

// ===== tb/sv/falling_sand_cell_step_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for falling_sand_cell_step_unit: write, read, step and spare requests
// against a behavioural grid predictor, with random idling on both channels.
// Depends on fsc_pkg and the channel interfaces in fsc_chan_if.sv.
module falling_sand_cell_step_unit_tb;
   import fsc_pkg::*;

   localparam int GRID_COLS  = DEF_MAX_COLS;
   localparam int GRID_ROWS  = DEF_MAX_ROWS;
   localparam int CELL_COUNT = DEF_MAX_COLS * DEF_MAX_ROWS;
   // the command encoding left unused by the block; it behaves as a read
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct {
      logic [KIND_W-1:0] kind;
      bit                kind_known;
      outcome_type       outcome;
      logic              bad;
   } cell_answer_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   fsc_req_if req_chan ();
   fsc_rsp_if rsp_chan ();

   falling_sand_cell_step_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [KIND_W-1:0] grid_model [CELL_COUNT];
   bit                cell_loaded [CELL_COUNT];
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   logic [KIND_W-1:0] sand_reg;
   logic [KIND_W-1:0] empty_reg;

   cell_answer_type pending_answers [$];
   int  fail_count     = 0;
   int  items_sent     = 0;
   int  move_count     = 0;
   int  off_grid_count = 0;
   int  settings_used  = 0;
   bit  steady_flow    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= steady_flow || ($urandom_range(99) >= 18);
   end

   function automatic int grid_cols();
      return (width_reg > GRID_COLS) ? GRID_COLS : int'(width_reg);
   endfunction

   function automatic int grid_rows();
      return (height_reg > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
   endfunction

   function automatic int cell_index(int c, int r);
      return r * GRID_COLS + c;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return sand_reg;
      if (roll < 75) return empty_reg;
      return KIND_W'($urandom_range(255));
   endfunction

   // true for a write, an off-grid request, or one that reads only loaded cells
   function automatic bit access_is_safe(logic [CMD_W-1:0] op, int c, int r);
      int w;
      int h;
      w = grid_cols();
      h = grid_rows();
      if (c >= w || r >= h || op == CMD_WRITE) return 1'b1;
      if (!cell_loaded[cell_index(c, r)]) return 1'b0;
      if (op != CMD_STEP || r + 1 >= h) return 1'b1;
      return cell_loaded[cell_index(c, r + 1)]
         && (c == 0 || cell_loaded[cell_index(c - 1, r + 1)])
         && (c + 1 >= w || cell_loaded[cell_index(c + 1, r + 1)]);
   endfunction

   function automatic cell_answer_type predict_cell_answer(logic [CMD_W-1:0] op, int c, int r,
                                                          logic [KIND_W-1:0] kind, bit right);
      cell_answer_type ans;
      int w;
      int h;
      int target;
      w = grid_cols();
      h = grid_rows();
      ans.kind = '0;
      ans.kind_known = 1'b1;
      ans.outcome = OUT_STAYED;
      ans.bad = 1'b0;
      if (c >= w || r >= h) begin
         ans.bad = 1'b1;
         return ans;
      end
      ans.kind = grid_model[cell_index(c, r)];
      ans.kind_known = cell_loaded[cell_index(c, r)];
      if (op == CMD_WRITE) begin
         grid_model[cell_index(c, r)] = kind;
         cell_loaded[cell_index(c, r)] = 1'b1;
      end else if (op == CMD_STEP && ans.kind == sand_reg && r + 1 < h) begin
         target = -1;
         if (grid_model[cell_index(c, r + 1)] == empty_reg) begin
            target = c;
            ans.outcome = OUT_FELL;
         end else if (right) begin
            if (c + 1 < w && grid_model[cell_index(c + 1, r + 1)] == empty_reg) begin
               target = c + 1;
               ans.outcome = OUT_RIGHT;
            end
         end else if (c > 0 && grid_model[cell_index(c - 1, r + 1)] == empty_reg) begin
            target = c - 1;
            ans.outcome = OUT_LEFT;
         end
         if (target >= 0) begin
            grid_model[cell_index(target, r + 1)] = sand_reg;
            grid_model[cell_index(c, r)] = empty_reg;
         end
      end
      return ans;
   endfunction

   // entered and left at a falling edge
   task automatic send_cell(logic [CMD_W-1:0] op, int c, int r, logic [KIND_W-1:0] kind,
                            bit right);
      cell_answer_type ans;
      while (!steady_flow && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= op;
      req_chan.col      <= c[COORD_W-1:0];
      req_chan.row      <= r[COORD_W-1:0];
      req_chan.kind_in  <= kind;
      req_chan.go_right <= right;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      ans = predict_cell_answer(op, c, r, kind, right);
      pending_answers.push_back(ans);
      items_sent++;
      if (ans.bad) off_grid_count++;
      else if (ans.outcome != OUT_STAYED) move_count++;
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_chan.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [DIM_W-1:0] data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_GRID_WIDTH:  width_reg  = data;
         CSR_GRID_HEIGHT: height_reg = data;
         CSR_SAND_KIND:   sand_reg   = data[KIND_W-1:0];
         CSR_EMPTY_KIND:  empty_reg  = data[KIND_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_grid(int w, int h, logic [KIND_W-1:0] sand_code,
                           logic [KIND_W-1:0] empty_code);
      write_csr(CSR_GRID_WIDTH, w[DIM_W-1:0]);
      write_csr(CSR_GRID_HEIGHT, h[DIM_W-1:0]);
      write_csr(CSR_SAND_KIND, DIM_W'(sand_code));
      write_csr(CSR_EMPTY_KIND, DIM_W'(empty_code));
      settings_used++;
   endtask

   task automatic send_random_request(int c0, int r0, int ww, int wh);
      logic [CMD_W-1:0] op;
      int roll;
      int c;
      int r;
      roll = $urandom_range(99);
      if (roll < 22) op = CMD_WRITE;
      else if (roll < 40) op = CMD_READ;
      else if (roll < 44) op = CMD_SPARE;
      else op = CMD_STEP;
      if ($urandom_range(99) < 8) begin
         c = $urandom_range(255);
         r = $urandom_range(255);
      end else begin
         c = c0 + $urandom_range(ww - 1);
         r = r0 + $urandom_range(wh - 1);
      end
      // never read a cell the grid has not been given yet
      if (!access_is_safe(op, c, r)) op = CMD_WRITE;
      send_cell(op, c, r, pick_kind(), 1'($urandom_range(1)));
   endtask

   // load a window of the grid, then stir it with mostly steps
   task automatic run_sand_phase(int cfg_w, int cfg_h, logic [KIND_W-1:0] sand_code,
                                 logic [KIND_W-1:0] empty_code, int c0, int r0, int ww,
                                 int wh, int extra);
      set_grid(cfg_w, cfg_h, sand_code, empty_code);
      for (int r = r0; r < r0 + wh; r++) begin
         for (int c = c0; c < c0 + ww; c++) begin
            if ($urandom_range(99) < 5) send_random_request(c0, r0, ww, wh);
            send_cell(CMD_WRITE, c, r, pick_kind(), 1'($urandom_range(1)));
         end
      end
      // hold the sender until the whole load has been answered
      drain_requests();
      for (int n = 0; n < extra; n++) send_random_request(c0, r0, ww, wh);
      drain_requests();
   endtask

   task automatic test_moves_default_grid();
      send_cell(CMD_WRITE, 0, 0, 8'd1, 1'b0);
      send_cell(CMD_WRITE, 0, 1, 8'd0, 1'b0);
      send_cell(CMD_WRITE, 1, 1, 8'hAA, 1'b0);
      send_cell(CMD_STEP, 0, 0, 8'd0, 1'b0);
      send_cell(CMD_READ, 0, 1, 8'd0, 1'b0);
      send_cell(CMD_WRITE, 1, 0, 8'd1, 1'b0);
      send_cell(CMD_WRITE, 2, 1, 8'd0, 1'b0);
      send_cell(CMD_STEP, 1, 0, 8'd0, 1'b1);
      // left wall: below is sand and there is no column to the left
      send_cell(CMD_WRITE, 0, 0, 8'd1, 1'b0);
      send_cell(CMD_STEP, 0, 0, 8'd0, 1'b0);
      // non-sand cell stays put
      send_cell(CMD_STEP, 1, 0, 8'd0, 1'b1);
      drain_requests();
   endtask

   task automatic test_far_edges();
      send_cell(CMD_WRITE, 255, 254, 8'd1, 1'b0);
      send_cell(CMD_WRITE, 255, 255, 8'hFF, 1'b1);
      send_cell(CMD_WRITE, 254, 255, 8'd0, 1'b0);
      send_cell(CMD_STEP, 255, 254, 8'd0, 1'b1);
      send_cell(CMD_STEP, 255, 254, 8'd0, 1'b0);
      send_cell(CMD_STEP, 254, 255, 8'd0, 1'b0);
      send_cell(CMD_SPARE, 255, 255, 8'd0, 1'b0);
      drain_requests();
   endtask

   task automatic test_off_grid();
      set_grid(4, 3, 8'd1, 8'd0);
      send_cell(CMD_READ, 4, 0, 8'd0, 1'b0);
      send_cell(CMD_STEP, 0, 3, 8'd0, 1'b1);
      send_cell(CMD_WRITE, 200, 200, 8'd5, 1'b0);
      drain_requests();
      set_grid(0, 256, 8'd1, 8'd0);
      send_cell(CMD_READ, 0, 0, 8'd0, 1'b0);
      drain_requests();
      set_grid(256, 0, 8'd1, 8'd0);
      send_cell(CMD_WRITE, 0, 0, 8'd9, 1'b0);
      drain_requests();
   endtask

   task automatic test_grid_limits();
      set_grid(511, 511, 8'd1, 8'd0);
      send_cell(CMD_READ, 255, 255, 8'd0, 1'b0);
      drain_requests();
      set_grid(256, 1, 8'd1, 8'd0);
      send_cell(CMD_STEP, 0, 0, 8'd0, 1'b0);
      send_cell(CMD_READ, 0, 1, 8'd0, 1'b0);
      drain_requests();
   endtask

   task automatic test_equal_codes();
      set_grid(256, 256, 8'd7, 8'd7);
      send_cell(CMD_WRITE, 5, 5, 8'd7, 1'b0);
      send_cell(CMD_WRITE, 5, 6, 8'd7, 1'b0);
      send_cell(CMD_WRITE, 4, 6, 8'd2, 1'b0);
      send_cell(CMD_WRITE, 6, 6, 8'd2, 1'b0);
      send_cell(CMD_STEP, 5, 5, 8'd0, 1'($urandom_range(1)));
      drain_requests();
   endtask

   task automatic test_random_sand();
      int w;
      int h;
      logic [KIND_W-1:0] sand_code;
      logic [KIND_W-1:0] empty_code;
      run_sand_phase(8, 6, 8'd1, 8'd0, 0, 0, 8, 6, 100);
      steady_flow = 1'b1;
      run_sand_phase(10, 7, 8'h5A, 8'hA5, 0, 0, 10, 7, 120);
      steady_flow = 1'b0;
      run_sand_phase(256, 256, 8'hFF, 8'h00, 248, 248, 8, 8, 120);
      run_sand_phase(1, 10, 8'd3, 8'd0, 0, 0, 1, 10, 80);
      run_sand_phase(300, 400, 8'h80, 8'h7F, 250, 100, 6, 6, 100);
      while (items_sent < 950) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(2, 10);
         sand_code = KIND_W'($urandom_range(255));
         empty_code = ($urandom_range(9) == 0) ? sand_code : KIND_W'($urandom_range(255));
         run_sand_phase(w, h, sand_code, empty_code, 0, 0, w, h, $urandom_range(60, 140));
      end
   endtask

   always @(posedge clock) begin : check_response
      cell_answer_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("response with no request outstanding: cell_kind %0d outcome %0d",
                   rsp_chan.cell_kind, rsp_chan.outcome);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (want.kind_known && rsp_chan.cell_kind !== want.kind) begin
               $error("cell_kind: expected %0d, got %0d", want.kind, rsp_chan.cell_kind);
               fail_count++;
            end
            if (rsp_chan.outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_chan.outcome);
               fail_count++;
            end
            if (rsp_chan.bad_coord !== want.bad) begin
               $error("bad_coord: expected %0d, got %0d", want.bad, rsp_chan.bad_coord);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      csr_wen           = 1'b0;
      csr_index         = CSR_GRID_WIDTH;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.cmd      = CMD_WRITE;
      req_chan.col      = '0;
      req_chan.row      = '0;
      req_chan.kind_in  = '0;
      req_chan.go_right = 1'b0;
      rsp_chan.ready    = 1'b0;
      width_reg         = RST_GRID_WIDTH;
      height_reg        = RST_GRID_HEIGHT;
      sand_reg          = RST_SAND_KIND;
      empty_reg         = RST_EMPTY_KIND;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_moves_default_grid();
      test_far_edges();
      test_off_grid();
      test_grid_limits();
      test_equal_codes();
      test_random_sand();

      drain_requests();
      // let any stray response surface
      repeat (20) @(posedge clock);
      $display("Sent %0d requests over %0d grid settings plus the reset defaults.",
               items_sent, settings_used);
      $display("Of these %0d moved sand and %0d addressed a cell outside the grid.",
               move_count, off_grid_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/fsc_pkg.sv
design/fsc_chan_if.sv
design/falling_sand_cell_step_unit.sv
tb/sv/falling_sand_cell_step_unit_tb.sv
